// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the checker file of the address parser.
// No dependencies; the including file supplies the clock and reset names.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FAP_ASSERT_IMPL(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("address parser assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define FAP_ASSERT_NEXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("address parser assertion failed");

// Next-cycle implication that is also checked across reset.
`define FAP_ASSERT_NEXT_ANY(name, clk, pre, post) \
    name: assert property (@(posedge clk) (pre) |=> (post)) \
        else $error("address parser assertion failed");

`endif

// ----- hw/rtl/fap_pkg.sv -----
// Shared types, character codes and the character classifier of the address parser.
// No dependencies.
package fap_pkg;

    localparam int OUT_W         = 16;
    localparam int FIELD_W_DEF   = 16;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [2:0] {
        CC_DIGIT,
        CC_ZONE_SEP,
        CC_NET_SEP,
        CC_NODE_SEP,
        CC_TERM,
        CC_OTHER
    } t_char_class;

    typedef struct packed {
        logic seen_zone;
        logic seen_net;
        logic seen_node;
        logic failed;
    } t_flags;

    function automatic t_char_class classify(input logic [7:0] c);
        t_char_class cls;
        if (c == CH_NUL || c == CH_AT || c == CH_SPACE || (c inside {[CH_TAB:CH_CR]})) begin
            cls = CC_TERM;
        end else if (c == CH_COLON) begin
            cls = CC_ZONE_SEP;
        end else if (c == CH_SLASH) begin
            cls = CC_NET_SEP;
        end else if (c == CH_DOT) begin
            cls = CC_NODE_SEP;
        end else if (c inside {[CH_ZERO:CH_NINE]}) begin
            cls = CC_DIGIT;
        end else begin
            cls = CC_OTHER;
        end
        return cls;
    endfunction

endpackage

// ----- hw/rtl/fap_step.sv -----
// Next-state and result logic for one address character.
// Depends on fap_pkg for the classifier, character codes and flag struct.
module fap_step import fap_pkg::*; #(
    parameter int FIELD_WIDTH = FIELD_W_DEF
) (
    input  logic [7:0]             i_char,
    input  t_flags                 i_flags,
    input  logic [FIELD_WIDTH-1:0] i_accum,
    input  logic [FIELD_WIDTH-1:0] i_zone,
    input  logic [FIELD_WIDTH-1:0] i_net,
    input  logic [FIELD_WIDTH-1:0] i_node,
    output t_flags                 o_flags,
    output logic [FIELD_WIDTH-1:0] o_accum,
    output logic [FIELD_WIDTH-1:0] o_zone,
    output logic [FIELD_WIDTH-1:0] o_net,
    output logic [FIELD_WIDTH-1:0] o_node,
    output logic                   o_term,
    output logic                   o_addr_ok,
    output logic [OUT_W-1:0]       o_zone_num,
    output logic [OUT_W-1:0]       o_net_num,
    output logic [OUT_W-1:0]       o_node_num,
    output logic [OUT_W-1:0]       o_point_num
);

    localparam int PROD_W = FIELD_WIDTH + 4;

    t_char_class           cls;
    logic [PROD_W-1:0]     acc_ext;
    logic [PROD_W-1:0]     prod;
    logic [FIELD_WIDTH-1:0] acc_sat;

    assign cls     = classify(i_char);
    assign acc_ext = PROD_W'(i_accum);
    assign prod    = (acc_ext << 3) + (acc_ext << 1) + PROD_W'(i_char - CH_ZERO);
    assign acc_sat = (|prod[PROD_W-1:FIELD_WIDTH]) ? {FIELD_WIDTH{1'b1}}
                                                    : prod[FIELD_WIDTH-1:0];

    always_comb begin
        o_flags = i_flags;
        o_accum = i_accum;
        o_zone  = i_zone;
        o_net   = i_net;
        o_node  = i_node;
        o_term  = 1'b0;

        if (cls == CC_TERM) begin
            o_term  = 1'b1;
            o_flags = '0;
            o_accum = '0;
            o_zone  = '0;
            o_net   = '0;
            o_node  = '0;
        end else if (!i_flags.failed) begin
            case (cls)
                CC_ZONE_SEP: begin
                    if (i_flags.seen_zone || i_flags.seen_net || i_flags.seen_node) begin
                        o_flags.failed = 1'b1;
                    end else begin
                        o_zone            = i_accum;
                        o_flags.seen_zone = 1'b1;
                        o_accum           = '0;
                    end
                end
                CC_NET_SEP: begin
                    if (i_flags.seen_net || i_flags.seen_node) begin
                        o_flags.failed = 1'b1;
                    end else begin
                        o_net            = i_accum;
                        o_flags.seen_net = 1'b1;
                        if (!i_flags.seen_zone) begin
                            o_zone            = FIELD_WIDTH'(1);
                            o_flags.seen_zone = 1'b1;
                        end
                        o_accum = '0;
                    end
                end
                CC_NODE_SEP: begin
                    if (!i_flags.seen_net || i_flags.seen_node) begin
                        o_flags.failed = 1'b1;
                    end else begin
                        o_node            = i_accum;
                        o_flags.seen_node = 1'b1;
                        o_accum           = '0;
                    end
                end
                CC_DIGIT: begin
                    o_accum = acc_sat;
                end
                default: begin
                    o_flags.failed = 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        o_addr_ok   = !i_flags.failed && i_flags.seen_net;
        o_zone_num  = '0;
        o_net_num   = '0;
        o_node_num  = '0;
        o_point_num = '0;
        if (o_addr_ok) begin
            o_zone_num  = OUT_W'(i_zone);
            o_net_num   = OUT_W'(i_net);
            o_node_num  = i_flags.seen_node ? OUT_W'(i_node) : OUT_W'(i_accum);
            o_point_num = i_flags.seen_node ? OUT_W'(i_accum) : '0;
        end
    end

endmodule

// ----- hw/rtl/fidonet_address_parser_core.sv -----
// Address parser top level: input register, parse state and result register.
// Depends on fap_pkg and fap_step.
// A terminator accepted into the input register raises o_valid once it steps into the result register.
// Throughput: one character per cycle; a terminator waits only while the result is stalled.
// Reset: synchronous, active low; it empties both registers and clears the parse state.
module fidonet_address_parser_core import fap_pkg::*; #(
    parameter int FIELD_WIDTH = FIELD_W_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [7:0]       i_char_in,
    output logic             o_stall,
    output logic             o_valid,
    output logic             o_addr_ok,
    output logic [OUT_W-1:0] o_zone_num,
    output logic [OUT_W-1:0] o_net_num,
    output logic [OUT_W-1:0] o_node_num,
    output logic [OUT_W-1:0] o_point_num,
    input  logic             i_stall
);

    logic                   r_in_valid;
    logic [7:0]             r_char;
    t_flags                 r_flags;
    logic [FIELD_WIDTH-1:0] r_accum;
    logic [FIELD_WIDTH-1:0] r_zone;
    logic [FIELD_WIDTH-1:0] r_net;
    logic [FIELD_WIDTH-1:0] r_node;
    logic                   r_out_valid;
    logic                   r_addr_ok;
    logic [OUT_W-1:0]       r_zone_num;
    logic [OUT_W-1:0]       r_net_num;
    logic [OUT_W-1:0]       r_node_num;
    logic [OUT_W-1:0]       r_point_num;

    t_flags                 n_flags;
    logic [FIELD_WIDTH-1:0] n_accum;
    logic [FIELD_WIDTH-1:0] n_zone;
    logic [FIELD_WIDTH-1:0] n_net;
    logic [FIELD_WIDTH-1:0] n_node;
    logic                   n_addr_ok;
    logic [OUT_W-1:0]       n_zone_num;
    logic [OUT_W-1:0]       n_net_num;
    logic [OUT_W-1:0]       n_node_num;
    logic [OUT_W-1:0]       n_point_num;

    logic step_term;
    logic out_free;
    logic step_fire;
    logic in_take;

    fap_step #(
        .FIELD_WIDTH(FIELD_WIDTH)
    ) u_step (
        .i_char      (r_char),
        .i_flags     (r_flags),
        .i_accum     (r_accum),
        .i_zone      (r_zone),
        .i_net       (r_net),
        .i_node      (r_node),
        .o_flags     (n_flags),
        .o_accum     (n_accum),
        .o_zone      (n_zone),
        .o_net       (n_net),
        .o_node      (n_node),
        .o_term      (step_term),
        .o_addr_ok   (n_addr_ok),
        .o_zone_num  (n_zone_num),
        .o_net_num   (n_net_num),
        .o_node_num  (n_node_num),
        .o_point_num (n_point_num)
    );

    assign out_free  = !r_out_valid || !i_stall;
    assign step_fire = r_in_valid && (!step_term || out_free);
    assign o_stall   = r_in_valid && !step_fire;
    assign in_take   = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_flags     <= '0;
            r_accum     <= '0;
            r_zone      <= '0;
            r_net       <= '0;
            r_node      <= '0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (step_fire) begin
                r_in_valid <= 1'b0;
            end

            if (step_fire) begin
                r_flags <= n_flags;
                r_accum <= n_accum;
                r_zone  <= n_zone;
                r_net   <= n_net;
                r_node  <= n_node;
            end

            if (step_fire && step_term) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_char <= i_char_in;
        end
        if (step_fire && step_term) begin
            r_addr_ok   <= n_addr_ok;
            r_zone_num  <= n_zone_num;
            r_net_num   <= n_net_num;
            r_node_num  <= n_node_num;
            r_point_num <= n_point_num;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_addr_ok   = r_addr_ok;
    assign o_zone_num  = r_zone_num;
    assign o_net_num   = r_net_num;
    assign o_node_num  = r_node_num;
    assign o_point_num = r_point_num;

endmodule

// ----- hw/rtl/fap_checker.sv -----
// Port-level checks for the address parser and the bind that attaches them.
// Depends on fap_pkg, assert_macros.svh and fidonet_address_parser_core.
`include "assert_macros.svh"

module fap_checker import fap_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_valid,
    input logic [7:0]       i_char_in,
    input logic             o_stall,
    input logic             o_valid,
    input logic             o_addr_ok,
    input logic [OUT_W-1:0] o_zone_num,
    input logic [OUT_W-1:0] o_net_num,
    input logic [OUT_W-1:0] o_node_num,
    input logic [OUT_W-1:0] o_point_num,
    input logic             i_stall
);

    `FAP_ASSERT_NEXT(a_result_held, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_addr_ok) && $stable(o_zone_num) && $stable(o_net_num) && $stable(o_node_num) && $stable(o_point_num))
    `FAP_ASSERT_IMPL(a_error_zero, i_clk, i_rst_n, o_valid && !o_addr_ok, o_zone_num == '0 && o_net_num == '0 && o_node_num == '0 && o_point_num == '0)
    `FAP_ASSERT_NEXT_ANY(a_reset_empty, i_clk, !i_rst_n, !o_valid && !o_stall)
    `FAP_ASSERT_NEXT(a_input_drains, i_clk, i_rst_n, o_stall && !i_stall, !o_stall)

endmodule

bind fidonet_address_parser_core fap_checker u_fap_checker (.*);

// ----- tb/fidonet_address_parser_checker.sv -----
`timescale 1ns / 100ps
// Result checker for the address parser: watches the character and result channels,
// predicts each address result from the accepted characters and compares it.
// Depends on fap_pkg for the port widths and the character codes.
module fidonet_address_parser_checker import fap_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_char_valid,
    input  logic [7:0]       i_char,
    input  logic             i_char_stall,
    input  logic             i_addr_valid,
    input  logic             i_addr_stall,
    input  logic             i_addr_ok,
    input  logic [OUT_W-1:0] i_zone_num,
    input  logic [OUT_W-1:0] i_net_num,
    input  logic [OUT_W-1:0] i_node_num,
    input  logic [OUT_W-1:0] i_point_num,
    output int               o_fail_count,
    output int               o_pending
);

    localparam int FW = FIELD_W_DEF;
    localparam logic [FW-1:0] FIELD_MAX = '1;

    typedef struct packed {
        logic             ok;
        logic [OUT_W-1:0] zone;
        logic [OUT_W-1:0] net;
        logic [OUT_W-1:0] node;
        logic [OUT_W-1:0] point;
    } t_addr_fields;

    typedef struct packed {
        logic          seen_zone;
        logic          seen_net;
        logic          seen_node;
        logic          failed;
        logic [FW-1:0] accum;
        logic [FW-1:0] zone;
        logic [FW-1:0] net;
        logic [FW-1:0] node;
    } t_parse_state;

    t_parse_state parse_st = '0;
    t_addr_fields expected_addr_q[$];
    int fail_cnt = 0;
    int pending_cnt = 0;

    assign o_fail_count = fail_cnt;
    assign o_pending    = pending_cnt;

    function automatic bit parse_char(input logic [7:0] c, output t_addr_fields res);
        logic [31:0] next_val;
        res = '0;
        if (c == CH_NUL || c == CH_AT || c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
            if (!parse_st.failed && parse_st.seen_net) begin
                res.ok    = 1'b1;
                res.zone  = parse_st.zone;
                res.net   = parse_st.net;
                res.node  = parse_st.seen_node ? parse_st.node : parse_st.accum;
                res.point = parse_st.seen_node ? parse_st.accum : '0;
            end
            parse_st = '0;
            return 1'b1;
        end
        if (!parse_st.failed) begin
            case (c)
                CH_COLON: begin
                    if (parse_st.seen_zone || parse_st.seen_net || parse_st.seen_node) begin
                        parse_st.failed = 1'b1;
                    end else begin
                        parse_st.zone      = parse_st.accum;
                        parse_st.seen_zone = 1'b1;
                        parse_st.accum     = '0;
                    end
                end
                CH_SLASH: begin
                    if (parse_st.seen_net || parse_st.seen_node) begin
                        parse_st.failed = 1'b1;
                    end else begin
                        parse_st.net      = parse_st.accum;
                        parse_st.seen_net = 1'b1;
                        if (!parse_st.seen_zone) begin
                            parse_st.zone      = FW'(1);
                            parse_st.seen_zone = 1'b1;
                        end
                        parse_st.accum = '0;
                    end
                end
                CH_DOT: begin
                    if (!parse_st.seen_net || parse_st.seen_node) begin
                        parse_st.failed = 1'b1;
                    end else begin
                        parse_st.node      = parse_st.accum;
                        parse_st.seen_node = 1'b1;
                        parse_st.accum     = '0;
                    end
                end
                default: begin
                    if (c >= CH_ZERO && c <= CH_NINE) begin
                        next_val = 32'(parse_st.accum) * 32'd10 + 32'(c - CH_ZERO);
                        parse_st.accum = (next_val > 32'(FIELD_MAX)) ? FIELD_MAX : FW'(next_val);
                    end else begin
                        parse_st.failed = 1'b1;
                    end
                end
            endcase
        end
        return 1'b0;
    endfunction

    always @(posedge i_clk) begin
        t_addr_fields got;
        t_addr_fields want;
        if (!i_rst_n) begin
            parse_st = '0;
            expected_addr_q.delete();
            pending_cnt <= 0;
        end else begin
            if (i_addr_valid && !i_addr_stall) begin
                got = {i_addr_ok, i_zone_num, i_net_num, i_node_num, i_point_num};
                if (expected_addr_q.size() == 0) begin
                    $display("%0t: unexpected address result, expected none, got ok=%0d %0d:%0d/%0d.%0d",
                             $time, got.ok, got.zone, got.net, got.node, got.point);
                    fail_cnt++;
                end else begin
                    want = expected_addr_q.pop_front();
                    if (got !== want) begin
                        $display("%0t: address mismatch, expected ok=%0d %0d:%0d/%0d.%0d, got ok=%0d %0d:%0d/%0d.%0d",
                                 $time, want.ok, want.zone, want.net, want.node, want.point,
                                 got.ok, got.zone, got.net, got.node, got.point);
                        fail_cnt++;
                    end
                end
            end
            if (i_char_valid && !i_char_stall) begin
                if (parse_char(i_char, want)) begin
                    expected_addr_q.push_back(want);
                end
            end
            pending_cnt <= expected_addr_q.size();
        end
    end

endmodule

// ----- tb/fidonet_address_parser_core_tb.sv -----
`timescale 1ns / 100ps
// Testbench top for the address parser: clock, reset, character stimulus, result stall pattern,
// watchdog and verdict. Depends on fap_pkg, fidonet_address_parser_core and fidonet_address_parser_checker.
module fidonet_address_parser_core_tb;
    import fap_pkg::*;

    localparam int CHAR_TARGET   = 1300;
    localparam int HOLD_AT       = 400;
    localparam int DRAIN_EVERY   = 300;
    localparam int LONG_HOLD     = 300;
    localparam int IDLE_LIMIT    = 5000;
    localparam int SETTLE_CYCLES = 8;
    localparam logic [7:0] ADDR_ENDS [8] = '{CH_NUL, CH_AT, CH_SPACE, CH_TAB,
                                             8'h0A, 8'h0B, 8'h0C, CH_CR};

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             char_valid = 1'b0;
    logic [7:0]       char_byte = CH_NUL;
    logic             char_stall;
    logic             addr_valid;
    logic             addr_ok;
    logic [OUT_W-1:0] zone_num;
    logic [OUT_W-1:0] net_num;
    logic [OUT_W-1:0] node_num;
    logic [OUT_W-1:0] point_num;
    logic             addr_stall = 1'b0;
    logic             hold_req = 1'b0;
    int               fail_count;
    int               pending;
    int               chars_sent = 0;
    int               burst_left = 0;
    int               idle_cycles = 0;
    logic [7:0]       addr_text[$];

    always #10 clk = ~clk;

    fidonet_address_parser_core u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_valid     (char_valid),
        .i_char_in   (char_byte),
        .o_stall     (char_stall),
        .o_valid     (addr_valid),
        .o_addr_ok   (addr_ok),
        .o_zone_num  (zone_num),
        .o_net_num   (net_num),
        .o_node_num  (node_num),
        .o_point_num (point_num),
        .i_stall     (addr_stall)
    );

    fidonet_address_parser_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_char_valid (char_valid),
        .i_char       (char_byte),
        .i_char_stall (char_stall),
        .i_addr_valid (addr_valid),
        .i_addr_stall (addr_stall),
        .i_addr_ok    (addr_ok),
        .i_zone_num   (zone_num),
        .i_net_num    (net_num),
        .i_node_num   (node_num),
        .i_point_num  (point_num),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    task automatic send_char(input logic [7:0] c);
        char_valid <= 1'b1;
        char_byte  <= c;
        do @(posedge clk); while (char_stall);
        chars_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end
        if (burst_left == 0) begin
            char_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_char(s[i]);
        end
    endtask

    task automatic drain_results();
        char_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    function automatic void push_number();
        int ndig;
        ndig = ($urandom_range(7) == 0) ? $urandom_range(5, 8) : $urandom_range(0, 4);
        repeat (ndig) addr_text.push_back(CH_ZERO + 8'($urandom_range(9)));
    endfunction

    function automatic void build_address();
        int kind;
        logic [7:0] odd;
        kind = $urandom_range(99);
        addr_text.delete();
        if (kind < 8) begin
            repeat ($urandom_range(1, 8)) addr_text.push_back(8'($urandom_range(255)));
        end else if (kind < 14) begin
            push_number();
            if (kind < 11) begin
                addr_text.push_back(CH_DOT);
                push_number();
            end
        end else begin
            if ($urandom_range(1) == 1) begin
                push_number();
                addr_text.push_back(CH_COLON);
            end
            push_number();
            addr_text.push_back(CH_SLASH);
            push_number();
            if ($urandom_range(1) == 1) begin
                addr_text.push_back(CH_DOT);
                push_number();
            end
            if (kind >= 82) begin
                case ($urandom_range(3))
                    0: odd = CH_COLON;
                    1: odd = CH_SLASH;
                    2: odd = CH_DOT;
                    default: odd = 8'($urandom_range(255));
                endcase
                addr_text.insert($urandom_range(addr_text.size()), odd);
            end
        end
        addr_text.push_back(ADDR_ENDS[$urandom_range(7)]);
    endfunction

    initial begin
        int next_drain;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_text("1:2/3.4@");
        send_text("/");
        send_char(CH_NUL);
        send_text("99999/");
        send_char(CH_TAB);
        send_text("5");
        send_char(CH_CR);
        send_char(CH_SPACE);
        send_text("1/2:x");
        send_char(8'h0A);
        send_text("7.8");
        send_char(8'h0C);
        drain_results();

        next_drain = chars_sent + DRAIN_EVERY;
        while (chars_sent < CHAR_TARGET) begin
            if (chars_sent >= HOLD_AT && !hold_req) begin
                hold_req <= 1'b1;
            end
            if (chars_sent >= next_drain) begin
                drain_results();
                next_drain += DRAIN_EVERY;
            end
            build_address();
            foreach (addr_text[i]) begin
                send_char(addr_text[i]);
            end
        end
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        int  stall_pct;
        int  mode_left;
        int  held;
        bit  hold_served;
        stall_pct   = 0;
        mode_left   = 0;
        held        = 0;
        hold_served = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req && !hold_served) begin
                addr_stall <= 1'b1;
                held++;
                hold_served = (held == LONG_HOLD);
            end else begin
                if (mode_left == 0) begin
                    case ($urandom_range(3))
                        0: stall_pct = 0;
                        1: stall_pct = 20;
                        2: stall_pct = 50;
                        default: stall_pct = 85;
                    endcase
                    mode_left = $urandom_range(20, 150);
                end
                mode_left--;
                addr_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (char_valid && !char_stall) || (addr_valid && !addr_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
